### sv/dpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared types and codes of the demand paging translator: request and
// response transaction payloads, mode, access, usage and status codes.
// ----------------------------------------------------------------------------
package dpt_pkg;

   // Request transaction payload
   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  space_id;
      logic [31:0] address;
      logic [1:0]  access_kind;
      logic [1:0]  usage_kind;
   } req_type;

   // Response transaction payload
   typedef struct packed {
      logic [31:0] result_address;
      logic [2:0]  status;
      logic [9:0]  frame_number;
      logic        is_valid;
      logic [31:0] access_count;
   } rsp_type;

   // Request modes
   localparam logic [1:0] MODE_TRANSLATE = 2'd0;
   localparam logic [1:0] MODE_REVERSE   = 2'd1;
   localparam logic [1:0] MODE_VALID     = 2'd2;
   localparam logic [1:0] MODE_COUNT     = 2'd3;

   // Access types of a translate
   localparam logic [1:0] ACC_FETCH        = 2'd0;
   localparam logic [1:0] ACC_LOAD_STORE   = 2'd1;
   localparam logic [1:0] ACC_GPU          = 2'd2;
   localparam logic [1:0] ACC_GPU_COHERENT = 2'd3;

   // Usage kinds of a count
   localparam logic [1:0] USE_READ  = 2'd0;
   localparam logic [1:0] USE_WRITE = 2'd1;
   localparam logic [1:0] USE_EXEC  = 2'd2;
   localparam logic [1:0] USE_BAD   = 2'd3;

   // Response status codes
   localparam logic [2:0] ST_HIT       = 3'd0;
   localparam logic [2:0] ST_NEW       = 3'd1;
   localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   // Page size register
   localparam logic [4:0] LOG_PAGE_RESET = 5'd12;
   localparam logic [4:0] LOG_PAGE_MIN   = 5'd10;
   localparam logic [4:0] LOG_PAGE_MAX   = 5'd16;

   // Entry layout and hash spread
   localparam int          KEY_W       = 31;
   localparam int          VPAGE_W     = 22;
   localparam logic [4:0]  SPACE_SPREAD = 5'd23;

endpackage : dpt_pkg
`default_nettype wire

### sv/demand_paging_translator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// demand_paging_translator_core
// Demand-paged address translator with on-demand sequential frame allocation.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. After acceptance a translate passes
// through the states BKT, HEAD, CHAIN and FIN, with one more CHAIN step for
// each further entry walked in its hash chain; reverse, valid and count
// requests and a gpu coherent translate go from BKT straight to FIN. FIN
// loads the response once the output register is free, and the block goes
// back to idle as the response is loaded, so the next request is accepted in
// the cycle after. The chain walk is paced by the single read port of the
// frame memory, which it visits one entry per cycle. A new request is taken
// while the previous response still waits in the output register. Counters
// of a frame are zeroed when the frame is allocated, so no clearing pass
// follows reset.
// ----------------------------------------------------------------------------
module demand_paging_translator_core #(
   parameter int MAX_FRAMES   = 1024,
   parameter int HASH_BUCKETS = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire dpt_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output dpt_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [4:0]       csr_data
);
   import dpt_pkg::*;

   localparam int FW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int UW   = $clog2(MAX_FRAMES + 1);
   localparam int BW   = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
   localparam int FE_W = KEY_W + FW + 1;
   localparam int CW   = 32;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_BKT   = 5'b00010,
      S_HEAD  = 5'b00100,
      S_CHAIN = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

   // Bucket of a (virtual page, space) pair
   function automatic logic [BW-1:0] bucket_of(input logic [VPAGE_W-1:0] vp,
                                               input logic [7:0] sp);
      logic [23:0]   sum;
      logic [BW-1:0] low;
      sum = 24'(vp) + 24'(sp) * 24'(SPACE_SPREAD);
      low = sum[BW-1:0];
      if (32'(low) >= 32'(HASH_BUCKETS)) begin
         low = BW'(32'(low) - 32'(HASH_BUCKETS));
      end
      return low;
   endfunction

   // Memories
   logic [FE_W-1:0] frame_mem [MAX_FRAMES];
   logic [FW-1:0]   bucket_mem [HASH_BUCKETS];
   logic [3*CW-1:0] cnt_mem [MAX_FRAMES];

   logic [FE_W-1:0] frame_rd_ff;
   logic [FW-1:0]   bucket_rd_ff;
   logic [3*CW-1:0] cnt_rd_ff;

   logic            frame_re, frame_we, bucket_we, cnt_we;
   logic [FW-1:0]   frame_raddr, frame_waddr;
   logic [FE_W-1:0] frame_wdata;
   logic [FW-1:0]   cnt_waddr;
   logic [3*CW-1:0] cnt_wdata;

   // Registers
   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [UW-1:0] used_ff, used_in;
   logic [4:0]    lg_ff, lg_in;
   logic [FW-1:0] cur_ff, cur_in;
   logic [FW-1:0] head_ff, head_in;
   logic          first_ff, first_in;
   logic [2:0]    tr_status_ff, tr_status_in;
   logic [FW-1:0] tr_frame_ff, tr_frame_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // Request decode
   logic [4:0]          lg_eff;
   logic [31:0]         offset;
   logic [31:0]         page32;
   logic [VPAGE_W-1:0]  page;
   logic [FW-1:0]       page_idx;
   logic [KEY_W-1:0]    key;
   logic [BW-1:0]       bucket;
   logic                page_used;

   // Chain entry decode
   logic [KEY_W-1:0]    ent_key;
   logic [FW-1:0]       ent_next;
   logic                ent_has_next;
   logic                head_ok, chain_ok;

   // Response build
   logic                out_free;
   rsp_type             fin_rsp;
   logic [CW-1:0]       cnt_old, cnt_new;

   always_comb begin
      if (lg_ff < LOG_PAGE_MIN) begin
         lg_eff = LOG_PAGE_MIN;
      end else if (lg_ff > LOG_PAGE_MAX) begin
         lg_eff = LOG_PAGE_MAX;
      end else begin
         lg_eff = lg_ff;
      end
   end

   assign offset    = req_ff.address & ((32'd1 << lg_eff) - 32'd1);
   assign page32    = req_ff.address >> lg_eff;
   assign page      = page32[VPAGE_W-1:0];
   assign page_idx  = page[FW-1:0];
   assign key       = {(req_ff.access_kind != ACC_FETCH), req_ff.space_id, page};
   assign bucket    = bucket_of(page, req_ff.space_id);
   assign page_used = page32 < 32'(used_ff);

   assign ent_key      = frame_rd_ff[KEY_W-1:0];
   assign ent_next     = frame_rd_ff[KEY_W+FW-1:KEY_W];
   assign ent_has_next = frame_rd_ff[FE_W-1];
   // A bucket head is trusted only if it names an allocated frame of this bucket
   assign head_ok      = (32'(cur_ff) < 32'(used_ff)) &&
                         (bucket_of(ent_key[VPAGE_W-1:0], ent_key[29:22]) == bucket);
   assign chain_ok     = first_ff ? head_ok : 1'b1;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Select the counter of the requested usage
   always_comb begin
      case (req_ff.usage_kind)
         USE_READ:  cnt_old = cnt_rd_ff[CW-1:0];
         USE_WRITE: cnt_old = cnt_rd_ff[2*CW-1:CW];
         USE_EXEC:  cnt_old = cnt_rd_ff[3*CW-1:2*CW];
         default:   cnt_old = '0;
      endcase
      cnt_new = (cnt_old == '1) ? cnt_old : cnt_old + CW'(1);
   end

   // Build the final response
   always_comb begin
      fin_rsp = '0;
      case (req_ff.mode)
         MODE_TRANSLATE: begin
            fin_rsp.status = tr_status_ff;
            if (tr_status_ff == ST_HIT || tr_status_ff == ST_NEW) begin
               fin_rsp.result_address = (32'(tr_frame_ff) << lg_eff) | offset;
               fin_rsp.frame_number   = 10'(32'(tr_frame_ff));
            end
         end
         MODE_REVERSE: begin
            fin_rsp.frame_number = page[9:0];
            if (page_used && ent_key[29:22] == req_ff.space_id) begin
               fin_rsp.result_address = (32'(ent_key[VPAGE_W-1:0]) << lg_eff) | offset;
               fin_rsp.status         = ST_HIT;
            end else begin
               fin_rsp.status = ST_NOT_FOUND;
            end
         end
         MODE_VALID: begin
            fin_rsp.frame_number = page[9:0];
            fin_rsp.is_valid     = page_used;
         end
         MODE_COUNT: begin
            fin_rsp.frame_number = page[9:0];
            if (req_ff.usage_kind == USE_BAD) begin
               fin_rsp.status = ST_BAD_TYPE;
            end else if (!page_used) begin
               fin_rsp.status = ST_NOT_FOUND;
            end else begin
               fin_rsp.access_count = cnt_new;
            end
         end
         default: fin_rsp = '0;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      used_in      = used_ff;
      lg_in        = lg_ff;
      cur_in       = cur_ff;
      head_in      = head_ff;
      first_in     = first_ff;
      tr_status_in = tr_status_ff;
      tr_frame_in  = tr_frame_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      frame_re     = 1'b0;
      frame_raddr  = page_idx;
      frame_we     = 1'b0;
      frame_waddr  = used_ff[FW-1:0];
      frame_wdata  = {chain_ok, head_ff, key};
      bucket_we    = 1'b0;
      cnt_we       = 1'b0;
      cnt_waddr    = used_ff[FW-1:0];
      cnt_wdata    = '0;

      // Take a page size write
      if (csr_valid) begin
         lg_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_BKT;
            end
         end
         S_BKT: begin
            frame_re     = 1'b1;
            frame_raddr  = page_idx;
            tr_status_in = ST_HIT;
            if (req_ff.mode != MODE_TRANSLATE) begin
               state_in = S_FIN;
            end else if (req_ff.access_kind == ACC_GPU_COHERENT) begin
               tr_status_in = ST_BAD_TYPE;
               state_in     = S_FIN;
            end else begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            frame_re    = 1'b1;
            frame_raddr = bucket_rd_ff;
            cur_in      = bucket_rd_ff;
            head_in     = bucket_rd_ff;
            first_in    = 1'b1;
            state_in    = S_CHAIN;
         end
         S_CHAIN: begin
            if (chain_ok && ent_key == key) begin
               tr_status_in = ST_HIT;
               tr_frame_in  = cur_ff;
               state_in     = S_FIN;
            end else if (chain_ok && ent_has_next) begin
               frame_re    = 1'b1;
               frame_raddr = ent_next;
               cur_in      = ent_next;
               first_in    = 1'b0;
            end else if (used_ff == UW'(MAX_FRAMES)) begin
               tr_status_in = ST_FULL;
               state_in     = S_FIN;
            end else begin
               // Allocate the next frame at the head of the bucket
               frame_we     = 1'b1;
               bucket_we    = 1'b1;
               cnt_we       = 1'b1;
               tr_status_in = ST_NEW;
               tr_frame_in  = used_ff[FW-1:0];
               used_in      = used_ff + UW'(1);
               state_in     = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = fin_rsp;
               state_in     = S_IDLE;
               if (req_ff.mode == MODE_COUNT && req_ff.usage_kind != USE_BAD &&
                   page_used) begin
                  cnt_we    = 1'b1;
                  cnt_waddr = page_idx;
                  cnt_wdata = cnt_rd_ff;
                  case (req_ff.usage_kind)
                     USE_READ:  cnt_wdata[CW-1:0]      = cnt_new;
                     USE_WRITE: cnt_wdata[2*CW-1:CW]   = cnt_new;
                     default:   cnt_wdata[3*CW-1:2*CW] = cnt_new;
                  endcase
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         lg_ff        <= LOG_PAGE_RESET;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         lg_ff        <= lg_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
      end
      req_ff       <= req_in;
      cur_ff       <= cur_in;
      head_ff      <= head_in;
      tr_status_ff <= tr_status_in;
      tr_frame_ff  <= tr_frame_in;
      rsp_ff       <= rsp_in;
   end

   // Frame entry memory
   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[frame_waddr] <= frame_wdata;
      end
      if (frame_re) begin
         frame_rd_ff <= frame_mem[frame_raddr];
      end
   end

   // Bucket head memory
   always_ff @(posedge clock) begin
      if (bucket_we) begin
         bucket_mem[bucket] <= used_ff[FW-1:0];
      end
      bucket_rd_ff <= bucket_mem[bucket];
   end

   // Usage counter memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (state_ff == S_BKT) begin
         cnt_rd_ff <= cnt_mem[page_idx];
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

endmodule : demand_paging_translator_core
`default_nettype wire
